### src/rrmq_pkg.sv
// shared types and constants for the range request merge queue
package rrmq_pkg;

   // queue geometry
   localparam int DEPTH = 64;
   localparam int OCC_W = $clog2(DEPTH + 1);

   // field widths
   localparam int START_W  = 63;
   localparam int COUNT_W  = 16;
   localparam int MCOUNT_W = 22;
   localparam int LIMIT_W  = 7;
   localparam int END_W    = START_W + 1;

   localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 7'd64;
   localparam logic [END_W-1:0]    MCOUNT_MAX  = END_W'((64'd1 << MCOUNT_W) - 64'd1);

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // one held request
   typedef struct packed {
      logic [START_W-1:0] start;
      logic [COUNT_W-1:0] count;
   } entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic      push;
      logic      shift;
      entry_type new_entry;
   } chain_ctrl_type;

endpackage

### src/range_request_merge_queue.sv
// top level of the range request merge queue
// On a push every cell compares its start against the new request
// and the row shifts right behind the insertion point, so the result is registered at
// the edge that takes the push. A pop walks the head of the cell row: it enters the
// merge state, the row shifts left by one for each merged request, and the pop finishes
// once no further request touches the merged range and the output register is free.
// A new item is taken whenever the block is idle and the output register is empty or
// being drained; the output register holds one finished result.
module range_request_merge_queue
   import rrmq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [START_W-1:0]  req_start_block,
   input  logic [COUNT_W-1:0]  req_block_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_dropped,
   output logic [START_W-1:0]  rsp_merged_start,
   output logic [MCOUNT_W-1:0] rsp_merged_count,
   output logic                rsp_queue_empty,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data
);

   localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_MERGE = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic                 first_ff, first_in;
   logic [START_W-1:0]   from_ff, from_in;
   logic [END_W-1:0]     end_ff, end_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 dropped_ff, dropped_in;
   logic [START_W-1:0]   mstart_ff, mstart_in;
   logic [MCOUNT_W-1:0]  mcount_ff, mcount_in;
   logic                 empty_ff, empty_in;

   logic                 out_free;
   logic                 req_xfer;
   logic                 full;
   logic                 push_go;
   logic                 absorb;
   logic                 merge_done;
   logic [CMP_W-1:0]     eff_limit;
   logic [END_W-1:0]     head_end;
   logic [END_W-1:0]     span;
   chain_ctrl_type       ctrl;
   entry_type            head;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_xfer  = req_valid && !req_stall;

   // limit clamped to the row length
   assign eff_limit = (CMP_W'(limit_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(limit_ff);
   assign full      = CMP_W'(occ_ff) >= eff_limit;
   assign push_go   = req_xfer && (req_cmd == CMD_PUSH) && !full;

   // merge walk over the head cell
   assign head_end   = END_W'(head.start) + END_W'(head.count);
   assign absorb     = (state_ff == ST_MERGE) && (occ_ff != '0)
                       && (first_ff || (END_W'(head.start) <= end_ff));
   assign merge_done = (state_ff == ST_MERGE) && !absorb && out_free;
   assign span       = end_ff - END_W'(from_ff);

   assign ctrl.push            = push_go;
   assign ctrl.shift           = absorb;
   assign ctrl.new_entry.start = req_start_block;
   assign ctrl.new_entry.count = req_block_count;

   rrmq_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .occupancy (occ_ff),
      .head      (head)
   );

   // control and result path
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      first_in     = first_ff;
      from_in      = from_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dropped_in   = dropped_ff;
      mstart_in    = mstart_ff;
      mcount_in    = mcount_ff;
      empty_in     = empty_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_cmd == CMD_PUSH) begin
                  rsp_valid_in = 1'b1;
                  dropped_in   = full;
                  mstart_in    = '0;
                  mcount_in    = '0;
                  empty_in     = full && (occ_ff == '0);
                  if (!full) begin
                     occ_in = occ_ff + OCC_W'(1);
                  end
               end else begin
                  state_in = ST_MERGE;
                  first_in = 1'b1;
                  from_in  = '0;
                  end_in   = '0;
               end
            end
         end
         ST_MERGE: begin
            if (absorb) begin
               occ_in   = occ_ff - OCC_W'(1);
               first_in = 1'b0;
               if (first_ff) begin
                  from_in = head.start;
                  end_in  = head_end;
               end else if (head_end > end_ff) begin
                  end_in = head_end;
               end
            end else if (merge_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               dropped_in   = 1'b0;
               mstart_in    = from_ff;
               mcount_in    = (span > MCOUNT_MAX) ? MCOUNT_MAX[MCOUNT_W-1:0]
                                                  : span[MCOUNT_W-1:0];
               empty_in     = (occ_ff == '0);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      first_ff   <= first_in;
      from_ff    <= from_in;
      end_ff     <= end_in;
      dropped_ff <= dropped_in;
      mstart_ff  <= mstart_in;
      mcount_ff  <= mcount_in;
      empty_ff   <= empty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dropped      = dropped_ff;
   assign rsp_merged_start = mstart_ff;
   assign rsp_merged_count = mcount_ff;
   assign rsp_queue_empty  = empty_ff;

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(occ_ff) <= eff_limit || CMP_W'(occ_ff) <= CMP_W'(DEPTH))
      else $error("occupancy beyond the row length");

   a_push_result: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_cmd == CMD_PUSH)) |=> (rsp_valid && (rsp_dropped == $past(full))))
      else $error("push transfer without matching result");

   a_merge_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |=> (occ_ff <= $past(occ_ff)))
      else $error("occupancy grew during a merge");

   a_drop_no_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> (rsp_merged_count == '0 && !rsp_queue_empty
                                      || rsp_merged_count == '0 && rsp_queue_empty))
      else $error("dropped push carries a merged range");

endmodule

### src/rrmq_cell.sv
// one storage cell of the sorted request chain
module rrmq_cell
   import rrmq_pkg::*;
(
   input  logic           clock,
   input  chain_ctrl_type ctrl,
   input  logic           occupied,
   input  logic           prev_le,
   input  entry_type      prev_entry,
   input  entry_type      next_entry,
   output logic           le,
   output entry_type      entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // held entry sorts at or before the pushed one
   assign le    = occupied && (entry_ff.start <= ctrl.new_entry.start);
   assign entry = entry_ff;

   // insert moves data right, pop moves data left
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (!le) begin
            entry_in = prev_le ? ctrl.new_entry : prev_entry;
         end
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### src/rrmq_chain.sv
// row of cells holding the requests sorted by start
module rrmq_chain
   import rrmq_pkg::*;
(
   input  logic             clock,
   input  chain_ctrl_type   ctrl,
   input  logic [OCC_W-1:0] occupancy,
   output entry_type        head
);

   entry_type cell_entry [DEPTH];
   logic      cell_le    [DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic      occ_here;
         logic      left_le;
         entry_type left_entry;
         entry_type right_entry;

         assign occ_here = occupancy > OCC_W'(i);

         // neighbor hookup: the first cell takes the new request from the left, the last cell folds back on itself
         if (i == 0) begin : g_first
            assign left_le    = 1'b1;
            assign left_entry = ctrl.new_entry;
         end else begin : g_inner
            assign left_le    = cell_le[i-1];
            assign left_entry = cell_entry[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[i];
         end else begin : g_more
            assign right_entry = cell_entry[i+1];
         end

         rrmq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (occ_here),
            .prev_le    (left_le),
            .prev_entry (left_entry),
            .next_entry (right_entry),
            .le         (cell_le[i]),
            .entry      (cell_entry[i])
         );
      end
   endgenerate

   assign head = cell_entry[0];

endmodule

### dv/tb_range_request_merge_queue.sv
// testbench for the range request merge queue: directed table, random traffic, scoreboard
`timescale 1ns / 1ps

module tb_range_request_merge_queue;
   import rrmq_pkg::*;

   localparam int PERIOD = 10;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = DEPTH + 4;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS [PHASES] = '{280, 170, 50, 280, 280, 280};
   localparam int PHASE_LIMIT [PHASES] = '{127, 3, 0, 64, 63, 0};

   localparam logic [START_W-1:0] START_MAX = '1;

   // one result item, field by field
   typedef struct packed {
      logic                dropped;
      logic [START_W-1:0]  merged_start;
      logic [MCOUNT_W-1:0] merged_count;
      logic                queue_empty;
   } merge_result_type;

   typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_type;

   // one line of the directed table
   typedef struct packed {
      row_kind_type       kind;
      logic               cmd;
      logic [START_W-1:0] start;
      logic [COUNT_W-1:0] count;
      logic [LIMIT_W-1:0] limit;
      logic               typed;
      merge_result_type   want;
   } plan_row_type;

   typedef enum int {SEQ_CLUSTER, SEQ_MIX, SEQ_NOISE, SEQ_TOP} seq_kind_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_type;

   localparam merge_result_type NO_WANT    = '{1'b0, 63'd0, 22'd0, 1'b0};
   localparam merge_result_type HELD_OK    = '{1'b0, 63'd0, 22'd0, 1'b0};
   localparam merge_result_type POP_EMPTY  = '{1'b0, 63'd0, 22'd0, 1'b1};
   localparam merge_result_type DROP_EMPTY = '{1'b1, 63'd0, 22'd0, 1'b1};
   localparam merge_result_type DROP_HELD  = '{1'b1, 63'd0, 22'd0, 1'b0};
   localparam merge_result_type TOP_POP    = '{1'b0, START_MAX, 22'd65535, 1'b1};

   // directed part: extremes, equal starts, touching and zero-length ranges, limits
   localparam int PLAN_ROWS = 28;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ROW_ITEM,  CMD_POP,  63'd0, 16'd0, 7'd0, 1'b1, POP_EMPTY},
      '{ROW_ITEM,  CMD_PUSH, START_MAX, 16'hFFFF, 7'd0, 1'b1, HELD_OK},
      '{ROW_ITEM,  CMD_POP,  63'd0, 16'd0, 7'd0, 1'b1, TOP_POP},
      '{ROW_ITEM,  CMD_PUSH, 63'd0, 16'd0, 7'd0, 1'b1, HELD_OK},
      '{ROW_ITEM,  CMD_PUSH, 63'd0, 16'd5, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'd5, 16'd3, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'd9, 16'd1, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'd8, 16'd0, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_POP,  63'd0, 16'd0, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_POP,  63'd0, 16'd0, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'd100, 16'hFFFF, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'd50, 16'd10, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'd60, 16'd40, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'h2AAA_AAAA_AAAA_AAAA, 16'hAAAA, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'h5555_5555_5555_5555, 16'h5555, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_POP,  63'd0, 16'd0, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_POP,  63'd0, 16'd0, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_POP,  63'd0, 16'd0, 7'd0, 1'b0, NO_WANT},
      '{ROW_LIMIT, CMD_PUSH, 63'd0, 16'd0, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'd7, 16'd7, 7'd0, 1'b1, DROP_EMPTY},
      '{ROW_ITEM,  CMD_POP,  63'd0, 16'd0, 7'd0, 1'b1, POP_EMPTY},
      '{ROW_LIMIT, CMD_PUSH, 63'd0, 16'd0, 7'd1, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'd3, 16'd4, 7'd0, 1'b1, HELD_OK},
      '{ROW_ITEM,  CMD_PUSH, 63'd1, 16'd1, 7'd0, 1'b1, DROP_HELD},
      '{ROW_LIMIT, CMD_PUSH, 63'd0, 16'd0, 7'd127, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_PUSH, 63'd2, 16'd1, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_POP,  63'd0, 16'd0, 7'd0, 1'b0, NO_WANT},
      '{ROW_ITEM,  CMD_POP,  63'd0, 16'd0, 7'd0, 1'b1, POP_EMPTY}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_cmd = CMD_PUSH;
   logic [START_W-1:0]  req_start_block = '0;
   logic [COUNT_W-1:0]  req_block_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_dropped;
   logic [START_W-1:0]  rsp_merged_start;
   logic [MCOUNT_W-1:0] rsp_merged_count;
   logic                rsp_queue_empty;
   logic                csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data = '0;

   // typed expectation travels with the payload so the monitor sees it at the transfer
   logic                item_typed = 1'b0;
   merge_result_type    item_want = NO_WANT;

   // mirror of the queue contents and the limit register
   logic [START_W-1:0]  held_start [DEPTH];
   logic [COUNT_W-1:0]  held_count [DEPTH];
   int                  held_n = 0;
   int                  limit_val = int'(LIMIT_RESET);

   merge_result_type    pending_results [$];
   int                  error_count = 0;
   int                  items_sent = 0;
   int                  results_seen = 0;
   int                  cycle_count = 0;
   int                  burst_left = 0;

   stall_mode_type      stall_mode = STALL_NONE;
   int                  stall_left = 0;
   logic [31:0]         stall_tick = '0;

   range_request_merge_queue dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_start_block  (req_start_block),
      .req_block_count  (req_block_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dropped      (rsp_dropped),
      .rsp_merged_start (rsp_merged_start),
      .rsp_merged_count (rsp_merged_count),
      .rsp_queue_empty  (rsp_queue_empty),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= 40)
         $display("%0t mismatch: %s", $time, msg);
   endtask

   // apply one request to the mirror and return the result it must give
   function automatic merge_result_type merge_queue_step(logic cmd, logic [START_W-1:0] first,
                                                         logic [COUNT_W-1:0] len);
      merge_result_type   r;
      int                 cap;
      int                 pos;
      int                 taken;
      int                 i;
      logic [END_W-1:0]   span_end;
      logic [END_W-1:0]   tail;
      logic [START_W-1:0] span_from;
      r = NO_WANT;
      cap = (limit_val < DEPTH) ? limit_val : DEPTH;
      if (cmd == CMD_PUSH) begin
         if (held_n >= cap) begin
            r.dropped = 1'b1;
         end else begin
            // equal starts go behind the ones already held
            pos = 0;
            while (pos < held_n && held_start[pos] <= first)
               pos++;
            for (i = held_n; i > pos; i--) begin
               held_start[i] = held_start[i-1];
               held_count[i] = held_count[i-1];
            end
            held_start[pos] = first;
            held_count[pos] = len;
            held_n++;
         end
      end else if (held_n > 0) begin
         // absorb every entry that starts at or before the running end
         span_from = held_start[0];
         span_end = END_W'(span_from);
         taken = 0;
         while (taken < held_n && END_W'(held_start[taken]) <= span_end) begin
            tail = END_W'(held_start[taken]) + END_W'(held_count[taken]);
            if (tail > span_end)
               span_end = tail;
            taken++;
         end
         for (i = taken; i < held_n; i++) begin
            held_start[i-taken] = held_start[i];
            held_count[i-taken] = held_count[i];
         end
         held_n -= taken;
         span_end = span_end - END_W'(span_from);
         r.merged_start = span_from;
         r.merged_count = (span_end > MCOUNT_MAX) ? MCOUNT_MAX[MCOUNT_W-1:0]
                                                  : span_end[MCOUNT_W-1:0];
      end
      r.queue_empty = (held_n == 0);
      return r;
   endfunction

   // result check, limit tracking and prediction at every edge
   always @(posedge clock) begin
      merge_result_type got;
      merge_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            got = '{rsp_dropped, rsp_merged_start, rsp_merged_count, rsp_queue_empty};
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", got));
            end else begin
               want = pending_results.pop_front();
               if (got.dropped !== want.dropped)
                  report_mismatch($sformatf("dropped %b, expected %b",
                                            got.dropped, want.dropped));
               if (got.merged_start !== want.merged_start)
                  report_mismatch($sformatf("merged_start %h, expected %h",
                                            got.merged_start, want.merged_start));
               if (got.merged_count !== want.merged_count)
                  report_mismatch($sformatf("merged_count %0d, expected %0d",
                                            got.merged_count, want.merged_count));
               if (got.queue_empty !== want.queue_empty)
                  report_mismatch($sformatf("queue_empty %b, expected %b",
                                            got.queue_empty, want.queue_empty));
            end
         end
         if (csr_wr_en)
            limit_val = int'(csr_wr_data);
         if (req_valid && !req_stall) begin
            want = merge_queue_step(req_cmd, req_start_block, req_block_count);
            if (item_typed)
               want = item_want;
            pending_results.push_back(want);
         end
      end
   end

   // receiver stall, switching between patterns of random duration
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         STALL_NONE:    rsp_stall <= 1'b0;
         STALL_RANDOM:  rsp_stall <= ($urandom_range(0, 99) < 35);
         STALL_PATTERN: rsp_stall <= stall_tick[1];
         default:       rsp_stall <= (stall_tick[2:0] != 3'd0);
      endcase
   end

   // present one request and hold it until the transfer
   task automatic send_item(logic cmd, logic [START_W-1:0] first, logic [COUNT_W-1:0] len,
                            logic typed, merge_result_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_start_block <= first;
      req_block_count <= len;
      item_typed <= typed;
      item_want <= want;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   // write the limit once every pending result has come back
   task automatic write_limit(logic [LIMIT_W-1:0] value);
      req_valid <= 1'b0;
      while (results_seen < items_sent)
         @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one random sequence of requests
   task automatic run_sequence();
      seq_kind_type       kind;
      int                 pick;
      int                 n;
      int                 spread;
      int                 pops;
      int                 i;
      logic               wide;
      logic               cmd;
      logic [START_W-1:0] base;
      logic [COUNT_W-1:0] len;
      pick = $urandom_range(0, 99);
      kind = (pick < 55) ? SEQ_CLUSTER : (pick < 80) ? SEQ_MIX :
             (pick < 92) ? SEQ_NOISE : SEQ_TOP;
      base = $urandom_range(0, 1) ? START_W'($urandom_range(0, 1000))
                                  : START_W'({$urandom, $urandom});
      case (kind)
         SEQ_CLUSTER: begin
            // fill with nearby ranges, then pop, with an occasional push mixed in; wide ones all merge
            n = $urandom_range(1, DEPTH + 8);
            spread = $urandom_range(1, 6);
            wide = ($urandom_range(0, 3) == 0);
            for (i = 0; i < n; i++) begin
               len = wide ? COUNT_W'($urandom_range(n * spread, 65535))
                          : COUNT_W'($urandom_range(0, 2 * spread));
               send_item(CMD_PUSH, base + START_W'($urandom_range(0, n * spread)), len,
                         1'b0, NO_WANT);
            end
            pops = $urandom_range(1, n + 1);
            for (i = 0; i < pops; i++) begin
               cmd = ($urandom_range(0, 9) == 0) ? CMD_PUSH : CMD_POP;
               send_item(cmd, base + START_W'($urandom_range(0, n * spread)),
                         COUNT_W'($urandom_range(0, 2 * spread)), 1'b0, NO_WANT);
            end
         end
         SEQ_MIX: begin
            for (i = 0; i < 24; i++) begin
               cmd = $urandom_range(0, 1) ? CMD_POP : CMD_PUSH;
               send_item(cmd, base + START_W'($urandom_range(0, 64)),
                         COUNT_W'($urandom_range(0, 40)), 1'b0, NO_WANT);
            end
         end
         SEQ_NOISE: begin
            for (i = 0; i < 16; i++) begin
               cmd = $urandom_range(0, 1) ? CMD_POP : CMD_PUSH;
               send_item(cmd, START_W'({$urandom, $urandom}), COUNT_W'($urandom), 1'b0,
                         NO_WANT);
            end
         end
         default: begin
            // ranges near the top of the block number space
            for (i = 0; i < 12; i++) begin
               cmd = ($urandom_range(0, 9) < 7) ? CMD_PUSH : CMD_POP;
               send_item(cmd, START_MAX - START_W'($urandom_range(0, 200000)),
                         COUNT_W'($urandom), 1'b0, NO_WANT);
            end
         end
      endcase
   endtask

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // main sequence: reset, directed table, random phases, drain
   initial begin
      int phase_end;
      logic [LIMIT_W-1:0] limit;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (PLAN[r]) begin
         if (PLAN[r].kind == ROW_LIMIT)
            write_limit(PLAN[r].limit);
         else
            send_item(PLAN[r].cmd, PLAN[r].start, PLAN[r].count, PLAN[r].typed,
                      PLAN[r].want);
      end
      for (int p = 0; p < PHASES; p++) begin
         limit = (p == PHASES - 1) ? LIMIT_W'($urandom_range(2, 62))
                                   : LIMIT_W'(PHASE_LIMIT[p]);
         write_limit(limit);
         phase_end = items_sent + PHASE_ITEMS[p];
         while (items_sent < phase_end)
            run_sequence();
      end
      req_valid <= 1'b0;
      while (results_seen < items_sent)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
